// ===== rtl/core/rtbc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtbc_pkg
// Shared types, constants and helper functions of the ranging timing-budget
// calculator.
// ----------------------------------------------------------------------------
package rtbc_pkg;

    localparam int unsigned EN_FINAL_BIT = 7;
    localparam int unsigned EN_PRE_BIT   = 6;
    localparam int unsigned EN_TCC_BIT   = 4;
    localparam int unsigned EN_DSS_BIT   = 3;
    localparam int unsigned EN_MSRC_BIT  = 2;

    localparam logic [31:0] OVH_START_SET = 32'd1320;
    localparam logic [31:0] OVH_START_GET = 32'd1910;
    localparam logic [31:0] OVH_END       = 32'd960;
    localparam logic [31:0] OVH_MSRC      = 32'd660;
    localparam logic [31:0] OVH_TCC       = 32'd590;
    localparam logic [31:0] OVH_DSS       = 32'd690;
    localparam logic [31:0] OVH_PRE       = 32'd660;
    localparam logic [31:0] OVH_FINAL     = 32'd550;
    localparam logic [31:0] MIN_BUDGET_US = 32'd20000;

    // macro period = 3813*p + floor((120*p + 500) / 1000)
    localparam logic [11:0] MP_BASE_MUL  = 12'd3813;
    localparam logic [16:0] RECIP_1000_S = 17'd67109;      // ceil(2^26/1000)
    localparam logic [29:0] RECIP_125    = 30'd549755814;  // ceil(2^36/125)
    localparam logic [9:0]  NS_PER_US    = 10'd1000;

    localparam int unsigned DIV_W = 32;
    localparam int unsigned MP_W  = 20;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_NO_FINAL = 2'd1,
        ST_BELOW    = 2'd2,
        ST_OVER     = 2'd3
    } status_t;

    typedef struct packed {
        logic [31:0] cur;
        status_t     status;
        logic [15:0] pre_m;
        logic        pre_en;
    } side_t;

    function automatic logic [7:0] pclk_count(input logic [7:0] code);
        logic [7:0] p;
        p = (code + 8'd1) << 1;
        return p;
    endfunction

    function automatic logic [15:0] decode_word(input logic [15:0] word);
        logic [15:0] v;
        if (word[15:8] >= 8'd16) begin
            v = 16'd0;
        end else begin
            v = 16'({8'd0, word[7:0]} << word[11:8]);
        end
        return v + 16'd1;
    endfunction

    function automatic logic [15:0] encode_word(input logic [15:0] mclks);
        logic [15:0] mant;
        logic [7:0]  ex;
        mant = mclks - 16'd1;
        ex   = 8'd0;
        for (int i = 0; i < 8; i++) begin
            if (mant[15:8] != 8'd0) begin
                mant = mant >> 1;
                ex   = ex + 8'd1;
            end
        end
        if (mclks == 16'd0) begin
            return 16'd0;
        end
        return {ex, mant[7:0]};
    endfunction

endpackage

// ===== rtl/core/rtbc_front.sv =====
// ----------------------------------------------------------------------------
// rtbc_front
// Six-stage front end: period and timeout decode, macro period, mclk to us
// conversion, budget sums, status and the dividend for the final timeout.
// ----------------------------------------------------------------------------
module rtbc_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [7:0]                   sequence_enables,
    input  logic [7:0]                   pre_period_code,
    input  logic [7:0]                   msrc_timeout_code,
    input  logic [15:0]                  pre_timeout_word,
    input  logic [7:0]                   final_period_code,
    input  logic [15:0]                  final_timeout_word,
    input  logic [31:0]                  requested_budget_us,
    output logic                         out_valid,
    output logic [rtbc_pkg::DIV_W-1:0]   dividend,
    output logic [rtbc_pkg::MP_W-1:0]    divisor,
    output rtbc_pkg::side_t              side
);
    import rtbc_pkg::*;

    logic [5:0] valid_reg;

    // stage 1
    logic [7:0]  en1_reg;
    logic [8:0]  msrc1_reg;
    logic [15:0] prem1_reg, finm1_reg;
    logic [31:0] req1_reg;
    logic [14:0] xpre1_reg, xfin1_reg;
    logic [19:0] bpre1_reg, bfin1_reg;
    // stage 2
    logic [7:0]  en2_reg;
    logic [8:0]  msrc2_reg;
    logic [15:0] prem2_reg, finm2_reg;
    logic [31:0] req2_reg;
    logic [19:0] mppre2_reg, mpfin2_reg;
    // stage 3
    logic [7:0]  en3_reg;
    logic [15:0] prem3_reg;
    logic [31:0] req3_reg;
    logic [19:0] mpfin3_reg;
    logic [31:0] xmsrc3_reg, xpre3_reg, xfin3_reg;
    // stage 4
    logic [7:0]  en4_reg;
    logic [15:0] prem4_reg;
    logic [31:0] req4_reg;
    logic [19:0] mpfin4_reg;
    logic [31:0] umsrc4_reg, upre4_reg, ufin4_reg;
    // stage 5
    logic [7:0]  en5_reg;
    logic [15:0] prem5_reg;
    logic [31:0] req5_reg;
    logic [19:0] mpfin5_reg;
    logic [31:0] ufin5_reg, common5_reg;
    // stage 6
    logic [31:0] dvd6_reg;
    logic [19:0] dvs6_reg;
    side_t       side6_reg;

    logic [7:0]  pre_p, fin_p;
    logic [15:0] pre_m, fin_m;
    logic [31:0] x_msrc_next, x_pre_next, x_fin_next;
    logic [31:0] common_next, cur_next, used_next, dvd_next;
    status_t     status_next;

    function automatic logic [19:0] mp_fix(input logic [19:0] base, input logic [14:0] x);
        logic [31:0] prod;
        prod = {17'd0, x} * {15'd0, RECIP_1000_S};
        return base + 20'(prod[31:26]);
    endfunction

    function automatic logic [31:0] mclk_term(input logic [15:0] m, input logic [19:0] mp);
        logic [35:0] prod;
        prod = {20'd0, m} * {16'd0, mp};
        return prod[31:0] + {13'd0, mp[19:1]};
    endfunction

    function automatic logic [31:0] div1000(input logic [31:0] x);
        logic [58:0] prod;
        prod = {30'd0, x[31:3]} * {29'd0, RECIP_125};
        return {9'd0, prod[58:36]};
    endfunction

    always_comb begin
        pre_p = pclk_count(pre_period_code);
        fin_p = pclk_count(final_period_code);
        pre_m = decode_word(pre_timeout_word);
        fin_m = decode_word(final_timeout_word);
        if (sequence_enables[EN_PRE_BIT]) begin
            fin_m = fin_m - pre_m;
        end
    end

    always_comb begin
        x_msrc_next = mclk_term({7'd0, msrc2_reg}, mppre2_reg);
        x_pre_next  = mclk_term(prem2_reg, mppre2_reg);
        x_fin_next  = mclk_term(finm2_reg, mpfin2_reg);
    end

    always_comb begin
        common_next = 32'd0;
        if (en4_reg[EN_TCC_BIT]) begin
            common_next = common_next + umsrc4_reg + OVH_TCC;
        end
        if (en4_reg[EN_DSS_BIT]) begin
            common_next = common_next + ((umsrc4_reg + OVH_DSS) << 1);
        end else if (en4_reg[EN_MSRC_BIT]) begin
            common_next = common_next + umsrc4_reg + OVH_MSRC;
        end
        if (en4_reg[EN_PRE_BIT]) begin
            common_next = common_next + upre4_reg + OVH_PRE;
        end
    end

    always_comb begin
        logic [41:0] scaled;
        cur_next = OVH_START_GET + OVH_END + common5_reg;
        if (en5_reg[EN_FINAL_BIT]) begin
            cur_next = cur_next + ufin5_reg + OVH_FINAL;
        end
        used_next = OVH_START_SET + OVH_END + common5_reg + OVH_FINAL;
        if (req5_reg < MIN_BUDGET_US) begin
            status_next = ST_BELOW;
        end else if (!en5_reg[EN_FINAL_BIT]) begin
            status_next = ST_NO_FINAL;
        end else if (used_next > req5_reg) begin
            status_next = ST_OVER;
        end else begin
            status_next = ST_DONE;
        end
        scaled   = {10'd0, req5_reg - used_next} * {32'd0, NS_PER_US};
        dvd_next = scaled[31:0] + {13'd0, mpfin5_reg[19:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            en1_reg   <= sequence_enables;
            msrc1_reg <= {1'b0, msrc_timeout_code} + 9'd1;
            prem1_reg <= pre_m;
            finm1_reg <= fin_m;
            req1_reg  <= requested_budget_us;
            xpre1_reg <= 15'({7'd0, pre_p} * 15'd120) + 15'd500;
            xfin1_reg <= 15'({7'd0, fin_p} * 15'd120) + 15'd500;
            bpre1_reg <= {12'd0, pre_p} * {8'd0, MP_BASE_MUL};
            bfin1_reg <= {12'd0, fin_p} * {8'd0, MP_BASE_MUL};

            en2_reg    <= en1_reg;
            msrc2_reg  <= msrc1_reg;
            prem2_reg  <= prem1_reg;
            finm2_reg  <= finm1_reg;
            req2_reg   <= req1_reg;
            mppre2_reg <= mp_fix(bpre1_reg, xpre1_reg);
            mpfin2_reg <= mp_fix(bfin1_reg, xfin1_reg);

            en3_reg    <= en2_reg;
            prem3_reg  <= prem2_reg;
            req3_reg   <= req2_reg;
            mpfin3_reg <= mpfin2_reg;
            xmsrc3_reg <= x_msrc_next;
            xpre3_reg  <= x_pre_next;
            xfin3_reg  <= x_fin_next;

            en4_reg    <= en3_reg;
            prem4_reg  <= prem3_reg;
            req4_reg   <= req3_reg;
            mpfin4_reg <= mpfin3_reg;
            umsrc4_reg <= div1000(xmsrc3_reg);
            upre4_reg  <= div1000(xpre3_reg);
            ufin4_reg  <= div1000(xfin3_reg);

            en5_reg     <= en4_reg;
            prem5_reg   <= prem4_reg;
            req5_reg    <= req4_reg;
            mpfin5_reg  <= mpfin4_reg;
            ufin5_reg   <= ufin4_reg;
            common5_reg <= common_next;

            dvd6_reg         <= dvd_next;
            dvs6_reg         <= mpfin5_reg;
            side6_reg.cur    <= cur_next;
            side6_reg.status <= status_next;
            side6_reg.pre_m  <= prem5_reg;
            side6_reg.pre_en <= en5_reg[EN_PRE_BIT];
        end
    end

    assign out_valid = valid_reg[5];
    assign dividend  = dvd6_reg;
    assign divisor   = dvs6_reg;
    assign side      = side6_reg;

endmodule

// ===== rtl/core/rtbc_div.sv =====
// ----------------------------------------------------------------------------
// rtbc_div
// Pipelined restoring divider, one quotient bit per stage. A zero divisor
// yields an all-ones quotient by construction.
// ----------------------------------------------------------------------------
module rtbc_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [rtbc_pkg::DIV_W-1:0]   dividend,
    input  logic [rtbc_pkg::MP_W-1:0]    divisor,
    input  rtbc_pkg::side_t              in_side,
    output logic                         out_valid,
    output logic [rtbc_pkg::DIV_W-1:0]   quotient,
    output rtbc_pkg::side_t              out_side
);
    import rtbc_pkg::*;

    logic [DIV_W-1:0] valid_reg;
    logic [MP_W-1:0]  rem_reg  [DIV_W];
    logic [DIV_W-1:0] dq_reg   [DIV_W];
    logic [MP_W-1:0]  dvs_reg  [DIV_W];
    side_t            side_reg [DIV_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (adv) begin
            valid_reg <= {valid_reg[DIV_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < DIV_W; k++) begin : g_stage
        logic [MP_W-1:0]  rem_in;
        logic [DIV_W-1:0] dq_in;
        logic [MP_W-1:0]  dvs_in;
        side_t            side_in;
        logic [MP_W:0]    trial;
        logic [MP_W:0]    diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign dq_in   = dividend;
            assign dvs_in  = divisor;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign dq_in   = dq_reg[k-1];
            assign dvs_in  = dvs_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, dq_in[DIV_W-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign take  = (trial >= {1'b0, dvs_in});

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_reg[k]  <= take ? diff[MP_W-1:0] : trial[MP_W-1:0];
                dq_reg[k]   <= {dq_in[DIV_W-2:0], take};
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[DIV_W-1];
    assign quotient  = dq_reg[DIV_W-1];
    assign out_side  = side_reg[DIV_W-1];

endmodule

// ===== rtl/core/rtbc_enc.sv =====
// ----------------------------------------------------------------------------
// rtbc_enc
// Output stage: add back the pre-range mclks when pre-range is enabled,
// re-encode the final-range timeout word (zero unless the status is done)
// and hold the result for the downstream side.
module rtbc_enc (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [rtbc_pkg::DIV_W-1:0]   quotient,
    input  rtbc_pkg::side_t              in_side,
    output logic                         m_valid,
    output logic [31:0]                  m_current_budget_us,
    output logic [15:0]                  m_new_final_timeout_word,
    output logic [1:0]                   m_budget_status
);
    import rtbc_pkg::*;

    logic        valid_reg;
    logic [31:0] cur_reg;
    logic [15:0] word_reg;
    logic [1:0]  status_reg;
    logic [15:0] mclks;
    logic [15:0] word_next;

    always_comb begin
        mclks = quotient[15:0];
        if (in_side.pre_en) begin
            mclks = mclks + in_side.pre_m;
        end
        word_next = (in_side.status == ST_DONE) ? encode_word(mclks) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cur_reg    <= in_side.cur;
            word_reg   <= word_next;
            status_reg <= in_side.status;
        end
    end

    assign m_valid                  = valid_reg;
    assign m_current_budget_us      = cur_reg;
    assign m_new_final_timeout_word = word_reg;
    assign m_budget_status          = status_reg;

endmodule

// ===== rtl/core/ranging_timing_budget_calc_core.sv =====
// ----------------------------------------------------------------------------
// ranging_timing_budget_calc_core
// Pipeline: 6 front-end stages, 32 divider stages and 1 output stage lie
// between request accept and result valid.
// Throughput: one request per cycle; the whole pipeline holds while the
// result is not taken. Synchronous active-low reset empties the pipeline.
// ----------------------------------------------------------------------------
module ranging_timing_budget_calc_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_sequence_enables,
    input  logic [7:0]  s_pre_period_code,
    input  logic [7:0]  s_msrc_timeout_code,
    input  logic [15:0] s_pre_timeout_word,
    input  logic [7:0]  s_final_period_code,
    input  logic [15:0] s_final_timeout_word,
    input  logic [31:0] s_requested_budget_us,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_current_budget_us,
    output logic [15:0] m_new_final_timeout_word,
    output logic [1:0]  m_budget_status
);
    import rtbc_pkg::*;

    logic             adv;
    logic             front_valid, div_valid;
    logic [DIV_W-1:0] dividend, quotient;
    logic [MP_W-1:0]  divisor;
    side_t            front_side, div_side;

    // advance every stage together while the output slot is free or drained
    assign adv     = m_ready || !m_valid;
    assign s_ready = adv;

    rtbc_front u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .adv                 (adv),
        .in_valid            (s_valid),
        .sequence_enables    (s_sequence_enables),
        .pre_period_code     (s_pre_period_code),
        .msrc_timeout_code   (s_msrc_timeout_code),
        .pre_timeout_word    (s_pre_timeout_word),
        .final_period_code   (s_final_period_code),
        .final_timeout_word  (s_final_timeout_word),
        .requested_budget_us (s_requested_budget_us),
        .out_valid           (front_valid),
        .dividend            (dividend),
        .divisor             (divisor),
        .side                (front_side)
    );

    rtbc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (front_valid),
        .dividend  (dividend),
        .divisor   (divisor),
        .in_side   (front_side),
        .out_valid (div_valid),
        .quotient  (quotient),
        .out_side  (div_side)
    );

    rtbc_enc u_enc (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .adv                      (adv),
        .in_valid                 (div_valid),
        .quotient                 (quotient),
        .in_side                  (div_side),
        .m_valid                  (m_valid),
        .m_current_budget_us      (m_current_budget_us),
        .m_new_final_timeout_word (m_new_final_timeout_word),
        .m_budget_status          (m_budget_status)
    );

endmodule
